// ===== hw/rtl/bla_pkg.sv =====
// bla_pkg: field widths, register indexes and reset values of the battery level averager
// no dependencies; imported by the interfaces, the top module and the testbench

package bla_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int IN_SPAN_W  = 12;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_LOW   = 2'd0,
        CFG_IN_HIGH  = 2'd1,
        CFG_OUT_LOW  = 2'd2,
        CFG_OUT_HIGH = 2'd3
    } t_cfg_idx;

    localparam logic [IN_SPAN_W-1:0] RST_IN_LOW   = 12'd1060;
    localparam logic [IN_SPAN_W-1:0] RST_IN_HIGH  = 12'd2150;
    localparam logic [LEVEL_W-1:0]   RST_OUT_LOW  = 8'd10;
    localparam logic [LEVEL_W-1:0]   RST_OUT_HIGH = 8'd230;

endpackage

// ===== hw/rtl/bla_ifs.sv =====
// bla_ifs: valid/ready channels of the battery level averager (samples, results, config writes)
// depends on bla_pkg for the payload widths

interface bla_sample_if import bla_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bla_result_if import bla_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               window_full;

    modport source (output valid, output level, output window_full, input ready);
    modport sink   (input valid, input level, input window_full, output ready);
endinterface

interface bla_cfg_if import bla_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bla_ram.sv =====
// bla_ram: generic single write port, single read port ram with registered read data
// no dependencies

module bla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bla_div.sv =====
// bla_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies; shared by the burst mean, window average and level mapping

module bla_div #(
    parameter int NW  = 20,
    parameter int DVW = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [NW-1:0]  o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [DVW-1:0] r_rem;
    logic [NW-1:0]  r_quo;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           n_bit;
    logic [DVW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        diff  = trial - {1'b0, r_dvs};
        n_bit = (trial >= {1'b0, r_dvs});
        n_rem = n_bit ? diff[DVW-1:0] : trial[DVW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // dividend bits shift out at the top as quotient bits shift in
                r_rem <= n_rem;
                r_quo <= {r_quo[NW-2:0], n_bit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/battery_level_averager_top.sv =====
// battery_level_averager_top: burst mean, ring average and linear level mapping
// depends on bla_pkg, bla_ifs, bla_ram and bla_div

// Within a burst one sample transfer is taken per cycle. The last sample of a
// burst starts a result sequence, during which no sample is taken. In that
// sequence the shared bit-serial divider, of dividend width N (20 at the
// default parameters), runs once for the burst mean, once for the window
// average and once for the level mapping, with a shift-add multiply between
// the last two. When the input span ends are equal the mapping division is
// skipped. The final step of the sequence also waits while the previous
// result is still held in the output register. Results wait in an output
// register, so samples of the next burst flow while one is pending.
// The ring of burst means sits in a ram and needs no clearing after reset.
// Configuration writes are always taken out of reset (ready held high).

module battery_level_averager_top import bla_pkg::*; #(
    parameter int BURST    = 20,
    parameter int WINDOW   = 16,
    parameter int ADC_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bla_sample_if.sink    i_smp,
    bla_result_if.source  o_res,
    bla_cfg_if.sink       i_cfg
);

    localparam int SMP_USE = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int AW      = ADC_BITS;
    localparam int SUM_W   = $clog2(BURST * ((1 << ADC_BITS) - 1) + 1);
    localparam int BC_W    = (BURST > 1) ? $clog2(BURST) : 1;
    localparam int WP_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TOT_W   = $clog2(WINDOW * ((1 << ADC_BITS) - 1) + 1);
    localparam int MW      = (AW > IN_SPAN_W) ? AW : IN_SPAN_W;
    localparam int PW      = MW + LEVEL_W;
    localparam int VW      = PW + 2;
    localparam int BSW     = $clog2(BURST + 1);
    localparam int NW_A    = (SUM_W > TOT_W) ? SUM_W : TOT_W;
    localparam int NW      = (NW_A > PW) ? NW_A : PW;
    localparam int DVW_A   = (BSW > CNT_W) ? BSW : CNT_W;
    localparam int DVW     = (DVW_A > IN_SPAN_W) ? DVW_A : IN_SPAN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_DIV_AVG,
        ST_MUL,
        ST_DIV_MAP,
        ST_MAP
    } t_state;

    t_state r_state;

    // configuration
    logic [IN_SPAN_W-1:0] r_in_low;
    logic [IN_SPAN_W-1:0] r_in_high;
    logic [LEVEL_W-1:0]   r_out_low;
    logic [LEVEL_W-1:0]   r_out_high;

    // burst and ring state
    logic [SUM_W-1:0] r_sum;
    logic [BC_W-1:0]  r_bcnt;
    logic [WP_W-1:0]  r_wpos;
    logic [CNT_W-1:0] r_fill;
    logic [TOT_W-1:0] r_total;

    // mapping datapath
    logic [MW-1:0]      r_dmag;
    logic [LEVEL_W-1:0] r_somag;
    logic [IN_SPAN_W-1:0] r_simag;
    logic               r_neg;
    logic [PW-1:0]      r_acc;
    logic [2:0]         r_mcnt;
    logic [PW-1:0]      r_q;

    // divider requests
    logic             r_div_start;
    logic             n_div_start;
    logic [NW-1:0]    r_div_a;
    logic [DVW-1:0]   r_div_b;
    logic             div_done;
    logic [NW-1:0]    div_quo;

    // result register
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_out_full;

    logic [AW-1:0]  ram_rdata;
    logic           ram_we;

    logic             smp_xfer;
    logic             burst_last;
    logic [SUM_W-1:0] n_sum;
    logic             full;
    logic [TOT_W-1:0] n_total;
    logic [CNT_W-1:0] n_fill;
    logic [WP_W-1:0]  n_wpos;
    logic [MW:0]      d;
    logic [LEVEL_W:0] so;
    logic [IN_SPAN_W:0] si;
    logic             span_zero;
    logic [PW-1:0]    n_acc;
    logic [VW-1:0]    n_v;
    logic [LEVEL_W-1:0] n_level;
    logic             out_free;

    assign i_smp.ready = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign smp_xfer    = i_smp.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;

    always_comb begin
        n_sum      = r_sum + SUM_W'(i_smp.sample[SMP_USE-1:0]);
        burst_last = (r_bcnt == BC_W'(BURST - 1));

        full    = (r_fill == CNT_W'(WINDOW));
        n_total = r_total - (full ? TOT_W'(ram_rdata) : TOT_W'(0))
                  + TOT_W'(div_quo[AW-1:0]);
        n_fill  = full ? r_fill : r_fill + CNT_W'(1);
        n_wpos  = (r_wpos == WP_W'(WINDOW - 1)) ? WP_W'(0) : r_wpos + WP_W'(1);

        // signed span terms, split into sign and magnitude
        d  = (MW+1)'(div_quo[AW-1:0]) - (MW+1)'(r_in_low);
        so = {1'b0, r_out_high} - {1'b0, r_out_low};
        si = {1'b0, r_in_high} - {1'b0, r_in_low};
        span_zero = (r_in_high == r_in_low);

        // msb first shift-add, one multiplier bit a cycle
        n_acc = {r_acc[PW-2:0], 1'b0} + (r_somag[LEVEL_W-1] ? PW'(r_dmag) : PW'(0));

        n_v = VW'(r_out_low) + (r_neg ? (VW'(0) - VW'(r_q)) : VW'(r_q));
        priority if (n_v[VW-1]) begin
            n_level = '0;
        end else if (n_v > VW'(r_out_high)) begin
            n_level = r_out_high;
        end else begin
            n_level = n_v[LEVEL_W-1:0];
        end

        ram_we = (r_state == ST_DIV_MEAN) && div_done;

        n_div_start = ((r_state == ST_IDLE) && smp_xfer && burst_last)
                      || ((r_state == ST_DIV_MEAN) && div_done)
                      || ((r_state == ST_MUL) && (r_mcnt == 3'd0) && !span_zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_low    <= RST_IN_LOW;
            r_in_high   <= RST_IN_HIGH;
            r_out_low   <= RST_OUT_LOW;
            r_out_high  <= RST_OUT_HIGH;
            r_sum       <= '0;
            r_bcnt      <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= n_div_start;

            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_IN_LOW:   r_in_low   <= i_cfg.data[IN_SPAN_W-1:0];
                    CFG_IN_HIGH:  r_in_high  <= i_cfg.data[IN_SPAN_W-1:0];
                    CFG_OUT_LOW:  r_out_low  <= i_cfg.data[LEVEL_W-1:0];
                    CFG_OUT_HIGH: r_out_high <= i_cfg.data[LEVEL_W-1:0];
                endcase
            end

            // a result loaded in ST_MAP takes precedence over the clear
            if (r_out_valid && o_res.ready && (r_state != ST_MAP)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (smp_xfer) begin
                        if (burst_last) begin
                            r_div_a     <= NW'(n_sum);
                            r_div_b     <= DVW'(BURST);
                            r_sum       <= '0;
                            r_bcnt      <= '0;
                            r_state     <= ST_DIV_MEAN;
                        end else begin
                            r_sum  <= n_sum;
                            r_bcnt <= r_bcnt + BC_W'(1);
                        end
                    end
                end
                ST_DIV_MEAN: begin
                    // oldest entry is already on the ram read port at r_wpos
                    if (div_done) begin
                        r_total     <= n_total;
                        r_fill      <= n_fill;
                        r_wpos      <= n_wpos;
                        r_div_a     <= NW'(n_total);
                        r_div_b     <= DVW'(n_fill);
                        r_state     <= ST_DIV_AVG;
                    end
                end
                ST_DIV_AVG: begin
                    if (div_done) begin
                        r_dmag  <= d[MW] ? MW'((MW+1)'(0) - d) : d[MW-1:0];
                        r_somag <= so[LEVEL_W] ? LEVEL_W'((LEVEL_W+1)'(0) - so)
                                               : so[LEVEL_W-1:0];
                        r_simag <= si[IN_SPAN_W] ? IN_SPAN_W'((IN_SPAN_W+1)'(0) - si)
                                                 : si[IN_SPAN_W-1:0];
                        r_neg   <= d[MW] ^ so[LEVEL_W] ^ si[IN_SPAN_W];
                        r_acc   <= '0;
                        r_mcnt  <= 3'd7;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_acc   <= n_acc;
                    r_somag <= {r_somag[LEVEL_W-2:0], 1'b0};
                    r_mcnt  <= r_mcnt - 3'd1;
                    if (r_mcnt == 3'd0) begin
                        if (span_zero) begin
                            // equal span ends: quotient term drops out
                            r_q     <= '0;
                            r_state <= ST_MAP;
                        end else begin
                            r_div_a     <= NW'(n_acc);
                            r_div_b     <= DVW'(r_simag);
                            r_state     <= ST_DIV_MAP;
                        end
                    end
                end
                ST_DIV_MAP: begin
                    if (div_done) begin
                        r_q     <= div_quo[PW-1:0];
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    if (out_free) begin
                        r_level     <= n_level;
                        r_out_full  <= full;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    bla_ram #(
        .WIDTH (AW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (div_quo[AW-1:0]),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    bla_div #(
        .NW  (NW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.level       = r_level;
    assign o_res.window_full = r_out_full;

endmodule

// ===== sim/battery_level_averager_top_tb.sv =====
// battery_level_averager_top_tb: self-checking bench for the battery level averager
// depends on bla_pkg, bla_ifs and the rtl below battery_level_averager_top

module battery_level_averager_top_tb;
    import bla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int BURST_LEN    = 20;
    localparam int RING_DEPTH   = 16;
    localparam int SETTLE_WAIT  = 200;
    localparam int LIMIT_CYCLES = 200000;
    localparam int BURSTS_PER_PHASE = 10;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               window_full;
    } t_level_result;

    typedef enum int {
        BURST_UNIFORM,
        BURST_CLUSTER,
        BURST_ALL_ZERO,
        BURST_ALL_MAX,
        BURST_ALTERNATE
    } t_burst_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bla_sample_if smp_if ();
    bla_result_if res_if ();
    bla_cfg_if    cfg_if ();

    battery_level_averager_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor copy of the registers and the averaging state
    logic [IN_SPAN_W-1:0] span_in_low   = RST_IN_LOW;
    logic [IN_SPAN_W-1:0] span_in_high  = RST_IN_HIGH;
    logic [LEVEL_W-1:0]   span_out_low  = RST_OUT_LOW;
    logic [LEVEL_W-1:0]   span_out_high = RST_OUT_HIGH;

    int unsigned          burst_acc   = 0;
    int                   burst_fill  = 0;
    logic [SAMPLE_W-1:0]  ring_means [RING_DEPTH];
    int                   ring_pos    = 0;
    int                   ring_fill   = 0;
    int unsigned          ring_total  = 0;

    t_level_result expected_levels [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_samples     = 0;
    int n_levels      = 0;
    int n_cfg_writes  = 0;
    int n_errors      = 0;
    int n_cycles      = 0;

    function automatic logic [LEVEL_W-1:0] map_to_level(input int unsigned avg);
        longint span_in;
        longint span_out;
        longint v;
        span_in  = longint'(span_in_high) - longint'(span_in_low);
        span_out = longint'(span_out_high) - longint'(span_out_low);
        v = longint'(span_out_low);
        // signed division truncates toward zero, as the mapping requires
        if (span_in != 0) begin
            v = v + (longint'(avg) - longint'(span_in_low)) * span_out / span_in;
        end
        if (v > longint'(span_out_high)) begin
            v = longint'(span_out_high);
        end
        if (v < 0) begin
            v = 0;
        end
        return v[LEVEL_W-1:0];
    endfunction

    task automatic update_level_estimate(input logic [SAMPLE_W-1:0] s);
        int unsigned   mean;
        t_level_result res;
        burst_acc  += s;
        burst_fill += 1;
        if (burst_fill == BURST_LEN) begin
            mean       = burst_acc / BURST_LEN;
            burst_acc  = 0;
            burst_fill = 0;
            if (ring_fill >= RING_DEPTH) begin
                ring_total -= ring_means[ring_pos];
            end
            ring_means[ring_pos] = mean[SAMPLE_W-1:0];
            ring_total += mean;
            ring_pos = (ring_pos + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) begin
                ring_fill++;
            end
            res.level       = map_to_level(ring_total / ring_fill);
            res.window_full = (ring_fill >= RING_DEPTH);
            expected_levels.push_back(res);
        end
    endtask

    // sample transfer; valid is left high so back-to-back items need no gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        update_level_estimate(s);
        n_samples++;
    endtask

    task automatic send_burst(input t_burst_shape shape);
        int centre;
        int v;
        centre = $urandom_range(4095);
        for (int k = 0; k < BURST_LEN; k++) begin
            case (shape)
                BURST_UNIFORM:   v = $urandom_range(4095);
                BURST_CLUSTER: begin
                    v = centre + int'($urandom_range(128)) - 64;
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                end
                BURST_ALL_ZERO:  v = 0;
                BURST_ALL_MAX:   v = 4095;
                default:         v = (k % 2 == 0) ? 0 : 4095;
            endcase
            send_sample(v[SAMPLE_W-1:0]);
        end
    endtask

    // drops valid, waits out every pending level, then lets the block settle
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_IN_LOW:   span_in_low   = d[IN_SPAN_W-1:0];
            CFG_IN_HIGH:  span_in_high  = d[IN_SPAN_W-1:0];
            CFG_OUT_LOW:  span_out_low  = d[LEVEL_W-1:0];
            CFG_OUT_HIGH: span_out_high = d[LEVEL_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic set_spans(input logic [11:0] il, input logic [11:0] ih,
                             input logic [7:0] ol, input logic [7:0] oh);
        write_reg(CFG_IN_LOW, il);
        write_reg(CFG_IN_HIGH, ih);
        write_reg(CFG_OUT_LOW, {4'd0, ol});
        write_reg(CFG_OUT_HIGH, {4'd0, oh});
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_random_spans();
        logic [11:0] a;
        logic [11:0] b;
        logic [7:0]  c;
        logic [7:0]  d;
        a = $urandom_range(4095);
        b = $urandom_range(4095);
        c = $urandom_range(255);
        d = $urandom_range(255);
        case ($urandom_range(3))
            0: begin
                // ordinary rising span
                if (a > b) {a, b} = {b, a};
            end
            1: begin
                a = $urandom_range(1) ? 12'hfff : 12'h000;
                b = $urandom_range(1) ? 12'hfff : 12'h000;
                c = $urandom_range(1) ? 8'hff : 8'h00;
                d = $urandom_range(1) ? 8'hff : 8'h00;
            end
            default: ;
        endcase
        set_spans(a, b, c, d);
    endtask

    // reset spans: clamp to zero, then mid levels
    task automatic test_reset_mapping();
        send_burst(BURST_ALL_ZERO);
        send_burst(BURST_ALL_MAX);
        send_burst(BURST_ALTERNATE);
        wait_idle();
    endtask

    task automatic test_span_corners();
        // equal span ends: quotient term dropped
        set_spans(12'd1000, 12'd1000, 8'd40, 8'd200);
        send_burst(BURST_UNIFORM);
        wait_idle();
        // reversed input span, negative divisor
        set_spans(12'd3000, 12'd500, 8'd20, 8'd240);
        send_burst(BURST_CLUSTER);
        wait_idle();
        // reversed output span
        set_spans(12'd500, 12'd3500, 8'd200, 8'd50);
        send_burst(BURST_CLUSTER);
        wait_idle();
        // register extremes
        set_spans(12'hfff, 12'hfff, 8'hff, 8'hff);
        send_burst(BURST_ALL_MAX);
        wait_idle();
        set_spans(12'h000, 12'h000, 8'h00, 8'h00);
        send_burst(BURST_ALL_ZERO);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_prob,
                                       input bit full_range);
        int pick;
        send_idle_pct = idle_pct;
        stall_pct     = stall_prob;
        if (full_range) begin
            set_spans(12'h000, 12'hfff, 8'h00, 8'hff);
        end else begin
            set_random_spans();
        end
        for (int b = 0; b < BURSTS_PER_PHASE; b++) begin
            pick = $urandom_range(9);
            if (pick < 6)       send_burst(BURST_CLUSTER);
            else if (pick < 8)  send_burst(BURST_UNIFORM);
            else if (pick == 8) send_burst(BURST_ALL_ZERO);
            else                send_burst(BURST_ALL_MAX);
        end
        wait_idle();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_level_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: level transfer with none expected: level %0d full %0d",
                         $time, res_if.level, res_if.window_full);
                n_errors++;
            end else begin
                want = expected_levels.pop_front();
                n_levels++;
                if (res_if.level !== want.level) begin
                    $display("%0t: level mismatch: expected %0d, got %0d",
                             $time, want.level, res_if.level);
                    n_errors++;
                end
                if (res_if.window_full !== want.window_full) begin
                    $display("%0t: window_full mismatch: expected %0d, got %0d",
                             $time, want.window_full, res_if.window_full);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d levels outstanding", $time,
                     expected_levels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_IN_LOW;
        cfg_if.data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_mapping();
        test_span_corners();
        test_random_traffic(0, 0, 1'b1);
        test_random_traffic(64, 0, 1'b0);
        test_random_traffic(0, 64, 1'b0);
        test_random_traffic(16, 16, 1'b0);

        $display("%0d samples in, %0d levels checked, %0d register writes",
                 n_samples, n_levels, n_cfg_writes);
        $display("covered clamps, equal and reversed spans, ring wrap and idle/stall mixes");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
